[sv/baar_pkg.sv]
`default_nettype none

package baar_pkg;

  // Field and counter widths.
  localparam int CHAN_W = 3;
  localparam int PIN_W  = 8;
  localparam int EV_W   = 2;
  localparam int CFG_W  = 15;
  localparam int HOLD_W = 20;
  localparam int REP_W  = 16;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 15'd50;
  localparam logic [CFG_W-1:0] REPEAT_RESET   = 15'd100;

  // Register indexes, taken from paddr[2].
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_REPEAT   = 1'b1;

  // Multiples of the repeat interval that mark the tiers and the pull-back.
  localparam int MUL_FAST     = 10;
  localparam int MUL_FASTEST  = 15;
  localparam int MUL_PULLBACK = 16;
  localparam int MUL_CLAMP    = 17;

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_NORMAL  = 2'd1;
  localparam logic [EV_W-1:0] EV_FAST    = 2'd2;
  localparam logic [EV_W-1:0] EV_FASTEST = 2'd3;

  // Thresholds derived from the configuration, held in registers.
  typedef struct packed {
    logic [CFG_W-1:0]  debounce;
    logic [CFG_W-1:0]  interval;
    logic [HOLD_W-1:0] fast;
    logic [HOLD_W-1:0] fastest;
    logic [HOLD_W-1:0] pullback;
    logic [HOLD_W-1:0] clamp;
  } thresh_t;

endpackage

`default_nettype wire

[sv/button_accelerating_auto_repeat.sv]
`default_nettype none

// Active-low key qualifier with accelerating auto-repeat for up to NUM_KEYS buttons.
// Each input item is one sampling tick for one button: s_tuser carries the channel,
// s_tdata the port byte and the pin mask. The button counts as pressed when the
// sample AND the mask is zero. Every item yields exactly one result item on the
// m_ side whose tdata holds the event code: none, normal, fast or fastest repeat.
// Throughput is one item per cycle while the receiver does not stall. An accepted
// item passes through the input register and then the result register, which
// drives m_tvalid: while the item sits in the input register, the channel's counter
// pair is read, updated and written back, and the result register is loaded at the
// same edge. That update sets the rate; one channel's items may follow back to back.
// When the receiver stalls, the result is held and the input register still
// takes one more item; s_tready then drops until the result is taken.
// Reset clears all counters, sets debounce to 50 and interval to 100 ticks and
// empties both registers. The APB registers should be written only while no item
// is in flight; new thresholds take effect once loaded into the threshold register.
module button_accelerating_auto_repeat #(
  parameter int NUM_KEYS = 8
) (
  input  wire         clk,
  input  wire         rst,
  // s_tdata: port_sample [7:0], pin_mask [15:8]
  input  wire  [15:0] s_tdata,
  // s_tuser: channel [2:0]
  input  wire  [2:0]  s_tuser,
  input  wire         s_tvalid,
  output logic        s_tready,
  // m_tdata: key_event [1:0], zero fill above
  output logic [7:0]  m_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  baar_pkg::thresh_t            thr;
  logic                         in_valid;
  logic [baar_pkg::CHAN_W-1:0]  in_channel;
  logic [baar_pkg::PIN_W-1:0]   in_sample;
  logic [baar_pkg::PIN_W-1:0]   in_mask;
  logic                         advance;
  logic                         s_accept;
  logic [baar_pkg::EV_W-1:0]    ev_comb;
  logic [baar_pkg::EV_W-1:0]    ev_q;

  baar_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // The stage moves on whenever the result register is empty or being taken.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_channel <= s_tuser;
      in_sample  <= s_tdata[7:0];
      in_mask    <= s_tdata[15:8];
    end
  end

  baar_core #(
    .NUM_KEYS (NUM_KEYS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .upd         (in_valid && advance),
    .channel     (in_channel),
    .port_sample (in_sample),
    .pin_mask    (in_mask),
    .thr         (thr),
    .key_event   (ev_comb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_q <= ev_comb;
    end
  end

  assign m_tdata = 8'(ev_q);

  // The output side is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // With no result waiting, the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // An item that leaves the input register appears as a result.
  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> m_tvalid)
    else $error("item lost between stages");

endmodule

`default_nettype wire

[sv/baar_cfg.sv]
`default_nettype none

module baar_cfg (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output baar_pkg::thresh_t     thr
);

  logic [baar_pkg::CFG_W-1:0] debounce;
  logic [baar_pkg::CFG_W-1:0] interval;
  logic                       wr_en;
  baar_pkg::thresh_t          thr_next;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; only the low 15 bits of the data are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= baar_pkg::DEBOUNCE_RESET;
      interval <= baar_pkg::REPEAT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        baar_pkg::REG_DEBOUNCE: debounce <= pwdata[baar_pkg::CFG_W-1:0];
        baar_pkg::REG_REPEAT:   interval <= pwdata[baar_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register selected by the address.
  always_comb begin
    case (paddr[2])
      baar_pkg::REG_DEBOUNCE: prdata = 32'(debounce);
      baar_pkg::REG_REPEAT:   prdata = 32'(interval);
      default:                prdata = '0;
    endcase
  end

  // Thresholds are constant multiples of the interval plus the debounce time.
  // The largest, d + 17r, stays below 2^20.
  always_comb begin
    thr_next.debounce = debounce;
    thr_next.interval = interval;
    thr_next.fast     = baar_pkg::HOLD_W'(debounce)
                      + baar_pkg::HOLD_W'(interval) * baar_pkg::HOLD_W'(baar_pkg::MUL_FAST);
    thr_next.fastest  = baar_pkg::HOLD_W'(debounce)
                      + baar_pkg::HOLD_W'(interval) * baar_pkg::HOLD_W'(baar_pkg::MUL_FASTEST);
    thr_next.pullback = baar_pkg::HOLD_W'(debounce)
                      + baar_pkg::HOLD_W'(interval) * baar_pkg::HOLD_W'(baar_pkg::MUL_PULLBACK);
    thr_next.clamp    = baar_pkg::HOLD_W'(debounce)
                      + baar_pkg::HOLD_W'(interval) * baar_pkg::HOLD_W'(baar_pkg::MUL_CLAMP);
  end

  always_ff @(posedge clk) begin
    thr <= thr_next;
  end

endmodule

`default_nettype wire

[sv/baar_core.sv]
`default_nettype none

module baar_core #(
  parameter int NUM_KEYS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          upd,
  input  wire  [baar_pkg::CHAN_W-1:0]  channel,
  input  wire  [baar_pkg::PIN_W-1:0]   port_sample,
  input  wire  [baar_pkg::PIN_W-1:0]   pin_mask,
  input  baar_pkg::thresh_t            thr,
  output logic [baar_pkg::EV_W-1:0]    key_event
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int WIDE_W = IDX_W + baar_pkg::CHAN_W;

  logic [baar_pkg::HOLD_W-1:0] hold_count   [NUM_KEYS];
  logic [baar_pkg::REP_W-1:0]  repeat_count [NUM_KEYS];

  logic [WIDE_W-1:0]           chan_wide;
  logic [IDX_W-1:0]            idx;
  logic                        in_range;
  logic                        pressed;
  logic [baar_pkg::HOLD_W-1:0] hold_cur;
  logic [baar_pkg::HOLD_W-1:0] hold_clamped;
  logic [baar_pkg::REP_W-1:0]  rep_cur;
  logic [baar_pkg::EV_W-1:0]   tier;
  logic [baar_pkg::HOLD_W-1:0] hold_next;
  logic [baar_pkg::REP_W-1:0]  rep_next;

  // Channel decode; channels at or beyond NUM_KEYS leave the counters alone.
  assign chan_wide = {{IDX_W{1'b0}}, channel};
  assign idx       = chan_wide[IDX_W-1:0];
  assign in_range  = chan_wide < WIDE_W'(NUM_KEYS);
  assign pressed   = (port_sample & pin_mask) == '0;

  assign hold_cur = hold_count[idx];
  assign rep_cur  = repeat_count[idx];

  // Pull an over-long hold back, pick the tier, then step the counters.
  always_comb begin
    hold_clamped = (hold_cur > thr.clamp) ? thr.pullback : hold_cur;
    if (hold_clamped > thr.fastest) begin
      tier = baar_pkg::EV_FASTEST;
    end else if (hold_clamped > thr.fast) begin
      tier = baar_pkg::EV_FAST;
    end else if (hold_clamped > baar_pkg::HOLD_W'(thr.debounce)) begin
      tier = baar_pkg::EV_NORMAL;
    end else begin
      tier = baar_pkg::EV_NONE;
    end

    key_event = baar_pkg::EV_NONE;
    rep_next  = rep_cur;
    hold_next = hold_clamped + 1'b1;
    if (!pressed) begin
      hold_next = '0;
      rep_next  = '0;
    end else if (tier != baar_pkg::EV_NONE) begin
      if (rep_cur > baar_pkg::REP_W'(thr.interval)) begin
        rep_next  = '0;
        key_event = tier;
      end else begin
        rep_next = rep_cur + 1'b1;
      end
    end
    if (!in_range) begin
      key_event = baar_pkg::EV_NONE;
    end
  end

  // Per-channel counter pair, written back when the item leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_count[k]   <= '0;
        repeat_count[k] <= '0;
      end
    end else if (upd && in_range) begin
      hold_count[idx]   <= hold_next;
      repeat_count[idx] <= rep_next;
    end
  end

endmodule

`default_nettype wire

[dv/tb_button_accelerating_auto_repeat.sv]
module tb_button_accelerating_auto_repeat;

  localparam int CYCLE_LIMIT = 400000;

  // One sampling tick for one button.
  typedef struct {
    bit [baar_pkg::CHAN_W-1:0] channel;
    bit [baar_pkg::PIN_W-1:0]  port_sample;
    bit [baar_pkg::PIN_W-1:0]  pin_mask;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  button_accelerating_auto_repeat u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Pending ticks, expected key events and the checker's bookkeeping.
  tick_t                       tick_q[$];
  logic [baar_pkg::EV_W-1:0]   key_event_q[$];
  int                          mismatch_cnt = 0;
  int                          cycle_cnt = 0;
  logic                        in_fire = 1'b0;
  logic                        out_fire = 1'b0;
  bit                          send_idle = 1'b0;
  bit                          rcv_idle = 1'b0;
  bit                          hold_req = 1'b0;
  logic                        rcv_hold = 1'b0;
  int                          gap_left = 0;
  int                          stall_left = 0;

  // Predictor state: per-channel counters and the thresholds in force.
  logic [baar_pkg::HOLD_W-1:0] hold_cnt [8] = '{default: '0};
  logic [baar_pkg::REP_W-1:0]  rep_cnt [8] = '{default: '0};
  logic [baar_pkg::CFG_W-1:0]  cfg_debounce = baar_pkg::DEBOUNCE_RESET;
  logic [baar_pkg::CFG_W-1:0]  cfg_interval = baar_pkg::REPEAT_RESET;

  // Advances one channel by one tick and returns the key event it yields.
  function automatic logic [baar_pkg::EV_W-1:0] predict_key_event(tick_t t);
    int unsigned               d;
    int unsigned               r;
    int unsigned               h;
    logic [baar_pkg::EV_W-1:0] tier;
    logic [baar_pkg::EV_W-1:0] ev;
    d = cfg_debounce;
    r = cfg_interval;
    ev = baar_pkg::EV_NONE;
    // A released button clears both counters.
    if ((t.port_sample & t.pin_mask) != '0) begin
      hold_cnt[t.channel] = '0;
      rep_cnt[t.channel] = '0;
      return baar_pkg::EV_NONE;
    end
    h = hold_cnt[t.channel];
    if (h > d + baar_pkg::MUL_CLAMP * r) h = d + baar_pkg::MUL_PULLBACK * r;
    if (h > d + baar_pkg::MUL_FASTEST * r) tier = baar_pkg::EV_FASTEST;
    else if (h > d + baar_pkg::MUL_FAST * r) tier = baar_pkg::EV_FAST;
    else if (h > d) tier = baar_pkg::EV_NORMAL;
    else tier = baar_pkg::EV_NONE;
    if (tier != baar_pkg::EV_NONE) begin
      if (rep_cnt[t.channel] > r) begin
        rep_cnt[t.channel] = '0;
        ev = tier;
      end else begin
        rep_cnt[t.channel] = rep_cnt[t.channel] + 1'b1;
      end
    end
    hold_cnt[t.channel] = baar_pkg::HOLD_W'(h + 1);
    return ev;
  endfunction

  function automatic tick_t mk_tick(bit [2:0] ch, bit [7:0] sample, bit [7:0] mask);
    tick_t t;
    t.channel = ch;
    t.port_sample = sample;
    t.pin_mask = mask;
    return t;
  endfunction

  // A pressed button: every masked pin reads low, the rest is random.
  function automatic tick_t held_tick(bit [2:0] ch);
    tick_t t;
    t.channel = ch;
    t.pin_mask = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
    t.port_sample = 8'($urandom) & ~t.pin_mask;
    return t;
  endfunction

  // A released button: at least one masked pin reads high.
  function automatic tick_t released_tick(bit [2:0] ch);
    tick_t t;
    t.channel = ch;
    t.pin_mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                             : 8'(1 << $urandom_range(0, 7));
    t.port_sample = 8'($urandom) | (t.pin_mask & (~t.pin_mask + 8'd1));
    return t;
  endfunction

  // Queues press-and-hold sequences on a few neighbouring channels, with
  // occasional random ticks on any channel mixed in.
  task automatic queue_holds(int n, int width, int span);
    int       plan [8];
    bit [2:0] base;
    bit [2:0] ch;
    tick_t    t;
    base = 3'($urandom);
    foreach (plan[k]) plan[k] = $urandom_range(1, span);
    repeat (n) begin
      ch = base + 3'($urandom_range(0, width - 1));
      if ($urandom_range(0, 15) == 0) begin
        t = mk_tick(3'($urandom), 8'($urandom), 8'($urandom));
      end else if (plan[ch] > 0) begin
        t = held_tick(ch);
        plan[ch]--;
      end else begin
        t = released_tick(ch);
        plan[ch] = $urandom_range(1, span);
      end
      tick_q.push_back(t);
    end
  endtask

  // Waits until every queued item has been taken and every result checked.
  task automatic wait_idle();
    while (tick_q.size() != 0 || s_tvalid || key_event_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic write_threshold(logic idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == baar_pkg::REG_DEBOUNCE) cfg_debounce = value[baar_pkg::CFG_W-1:0];
    else cfg_interval = value[baar_pkg::CFG_W-1:0];
  endtask

  task automatic run_phase(int d_val, int r_val, int n, int width, bit snd, bit rcv);
    wait_idle();
    write_threshold(baar_pkg::REG_DEBOUNCE, {17'($urandom), 15'(d_val)});
    write_threshold(baar_pkg::REG_REPEAT, {17'($urandom), 15'(r_val)});
    repeat (3) @(posedge clk);
    send_idle = snd;
    rcv_idle = rcv;
    queue_holds(n, width, d_val + baar_pkg::MUL_CLAMP * r_val + 8);
  endtask

  // Sender: offers the next pending item after a random gap.
  always @(negedge clk) begin
    logic  offer;
    tick_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = s_tvalid && !in_fire;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() != 0) begin
          t = tick_q.pop_front();
          s_tuser <= t.channel;
          s_tdata <= {t.pin_mask, t.port_sample};
          offer = 1'b1;
          gap_left = send_idle ? $urandom_range(0, 12) : 0;
        end
      end
      s_tvalid <= offer;
    end
  end

  // Receiver: stalls at random after each result, or during a long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_fire && rcv_idle) stall_left = $urandom_range(0, 12);
      if (rcv_hold) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering items.
  initial begin
    wait (hold_req);
    repeat (20) @(negedge clk);
    rcv_hold <= 1'b1;
    repeat (150) @(negedge clk);
    rcv_hold <= 1'b0;
  end

  // Monitor: predicts on each accepted tick and checks each accepted result.
  always @(posedge clk) begin
    tick_t                     t;
    logic [baar_pkg::EV_W-1:0] want;
    in_fire <= !rst && s_tvalid && s_tready;
    out_fire <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) begin
      t = mk_tick(s_tuser, s_tdata[7:0], s_tdata[15:8]);
      key_event_q.push_back(predict_key_event(t));
    end
    if (!rst && m_tvalid && m_tready) begin
      if (key_event_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("unexpected result: key_event %0d", m_tdata[1:0]);
        mismatch_cnt++;
      end else begin
        want = key_event_q.pop_front();
        if (m_tdata[baar_pkg::EV_W-1:0] !== want) begin
          if (mismatch_cnt < 10)
            $display("key_event mismatch: expected %0d, got %0d", want, m_tdata[1:0]);
          mismatch_cnt++;
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Field extremes and the zero mask case at the reset thresholds.
    send_idle = 1'b1;
    rcv_idle = 1'b1;
    tick_q.push_back(mk_tick(3'd0, 8'hFF, 8'hFF));
    tick_q.push_back(mk_tick(3'd7, 8'h00, 8'hFF));
    tick_q.push_back(mk_tick(3'd3, 8'hFF, 8'h00));
    tick_q.push_back(mk_tick(3'd5, 8'hAA, 8'h55));
    tick_q.push_back(mk_tick(3'd5, 8'h01, 8'h01));
    tick_q.push_back(mk_tick(3'd2, 8'h7F, 8'h80));

    // Thresholds changed mid-hold; channel 7 then climbs through every tier
    // and into the pull-back. Upper register bits are ignored.
    wait_idle();
    write_threshold(baar_pkg::REG_DEBOUNCE, 32'hFFFF_8001);
    write_threshold(baar_pkg::REG_REPEAT, 32'h0001_0001);
    repeat (3) @(posedge clk);
    repeat (19) tick_q.push_back(held_tick(3'd7));

    // Register extremes.
    run_phase(32767, 32767, 20, 2, 1'b1, 1'b1);
    run_phase(32767, 0, 20, 2, 1'b0, 1'b1);

    // Random holds; the receiver holds off while the sender keeps going.
    run_phase(2, 2, 300, 2, 1'b0, 1'b0);
    hold_req = 1'b1;
    // Sender pauses until every result has come, then continues.
    wait_idle();
    send_idle = 1'b1;
    rcv_idle = 1'b1;
    queue_holds(100, 2, 2 + baar_pkg::MUL_CLAMP * 2 + 8);
    run_phase(0, 1, 150, 2, 1'b1, 1'b0);
    run_phase(5, 3, 250, 2, 1'b1, 1'b1);
    run_phase(1, 0, 100, 1, 1'b0, 1'b1);
    run_phase(0, 0, 60, 3, 1'b1, 1'b1);
    run_phase(3, 1, 150, 3, 1'b1, 1'b1);
    run_phase($urandom_range(0, 6), $urandom_range(0, 4), 140, 2, 1'b1, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
